FILE: src/hed_pkg.sv
// shared types, character codes and the named-entity rom for the entity decoder
// no dependencies
package hed_pkg;

   localparam int ROM_SIZE     = 49;
   localparam int ROM_TEXT_LEN = 8;
   localparam int RUN_CNT_W    = 5;

   localparam logic [7:0] AMP_CHAR  = 8'h26;
   localparam logic [7:0] SEMI_CHAR = 8'h3B;

   typedef struct packed {
      logic [3:0]  len;
      logic [63:0] text;
      logic        two;
      logic [7:0]  b0;
      logic [7:0]  b1;
   } rom_entry_type;

   typedef struct packed {
      logic       hit;
      logic       two;
      logic [7:0] b0;
      logic [7:0] b1;
   } match_type;

   typedef struct packed {
      logic                 load;
      logic [RUN_CNT_W-1:0] count;
      logic                 stream_end;
   } run_ctl_type;

   // text is right aligned: the last character sits in the low byte
   localparam rom_entry_type ROM [ROM_SIZE] = '{
      '{4'd6, 64'("Aacute"), 1'b1, 8'hC3, 8'h81},
      '{4'd5, 64'("Acirc"),  1'b1, 8'hC3, 8'h82},
      '{4'd5, 64'("AElig"),  1'b1, 8'hC3, 8'h86},
      '{4'd6, 64'("Agrave"), 1'b1, 8'hC3, 8'h80},
      '{4'd4, 64'("Auml"),   1'b1, 8'hC3, 8'h84},
      '{4'd6, 64'("Ccedil"), 1'b1, 8'hC3, 8'h87},
      '{4'd6, 64'("Eacute"), 1'b1, 8'hC3, 8'h89},
      '{4'd5, 64'("Ecirc"),  1'b1, 8'hC3, 8'h8A},
      '{4'd6, 64'("Egrave"), 1'b1, 8'hC3, 8'h88},
      '{4'd4, 64'("Euml"),   1'b1, 8'hC3, 8'h8B},
      '{4'd6, 64'("Iacute"), 1'b1, 8'hC3, 8'h8D},
      '{4'd5, 64'("Icirc"),  1'b1, 8'hC3, 8'h8E},
      '{4'd6, 64'("Igrave"), 1'b1, 8'hC3, 8'h8C},
      '{4'd4, 64'("Iuml"),   1'b1, 8'hC3, 8'h8F},
      '{4'd6, 64'("Oacute"), 1'b1, 8'hC3, 8'h93},
      '{4'd5, 64'("Ocirc"),  1'b1, 8'hC3, 8'h94},
      '{4'd5, 64'("OElig"),  1'b1, 8'hC5, 8'h92},
      '{4'd6, 64'("Ograve"), 1'b1, 8'hC3, 8'h92},
      '{4'd4, 64'("Ouml"),   1'b1, 8'hC3, 8'h96},
      '{4'd6, 64'("Otilde"), 1'b1, 8'hC3, 8'h95},
      '{4'd6, 64'("Yacute"), 1'b1, 8'hC3, 8'h9D},
      '{4'd4, 64'("Yuml"),   1'b1, 8'hC5, 8'hB8},
      '{4'd6, 64'("aacute"), 1'b1, 8'hC3, 8'hA1},
      '{4'd5, 64'("acirc"),  1'b1, 8'hC3, 8'hA2},
      '{4'd5, 64'("aelig"),  1'b1, 8'hC3, 8'hA6},
      '{4'd6, 64'("agrave"), 1'b1, 8'hC3, 8'hA0},
      '{4'd3, 64'("amp"),    1'b0, 8'h26, 8'h00},
      '{4'd4, 64'("auml"),   1'b1, 8'hC3, 8'hA4},
      '{4'd6, 64'("ccedil"), 1'b1, 8'hC3, 8'hA7},
      '{4'd6, 64'("eacute"), 1'b1, 8'hC3, 8'hA9},
      '{4'd5, 64'("ecirc"),  1'b1, 8'hC3, 8'hAA},
      '{4'd6, 64'("egrave"), 1'b1, 8'hC3, 8'hA8},
      '{4'd4, 64'("euml"),   1'b1, 8'hC3, 8'hAB},
      '{4'd2, 64'("gt"),     1'b0, 8'h3E, 8'h00},
      '{4'd6, 64'("iacute"), 1'b1, 8'hC3, 8'hAD},
      '{4'd5, 64'("icirc"),  1'b1, 8'hC3, 8'hAE},
      '{4'd6, 64'("igrave"), 1'b1, 8'hC3, 8'hAC},
      '{4'd4, 64'("iuml"),   1'b1, 8'hC3, 8'hAF},
      '{4'd2, 64'("lt"),     1'b0, 8'h3C, 8'h00},
      '{4'd4, 64'("nbsp"),   1'b1, 8'hC2, 8'hA0},
      '{4'd5, 64'("ndash"),  1'b0, 8'h2D, 8'h00},
      '{4'd6, 64'("oacute"), 1'b1, 8'hC3, 8'hB3},
      '{4'd5, 64'("ocirc"),  1'b1, 8'hC3, 8'hB4},
      '{4'd5, 64'("oelig"),  1'b1, 8'hC5, 8'h93},
      '{4'd6, 64'("ograve"), 1'b1, 8'hC3, 8'hB2},
      '{4'd4, 64'("ouml"),   1'b1, 8'hC3, 8'hB6},
      '{4'd6, 64'("otilde"), 1'b1, 8'hC3, 8'hB5},
      '{4'd6, 64'("yacute"), 1'b1, 8'hC3, 8'hBD},
      '{4'd4, 64'("yuml"),   1'b1, 8'hC3, 8'hBF}
   };

   // character pos of rom entry idx, counted from the start of the name
   function automatic logic [7:0] rom_char(input int idx, input int pos);
      logic [63:0] aligned;
      aligned = ROM[idx].text << (8 * (ROM_TEXT_LEN - int'(ROM[idx].len)));
      return aligned[63 - 8 * pos -: 8];
   endfunction

endpackage

FILE: src/html_entity_decoder.sv
// html named character reference decoder, top level
// depends on hed_pkg, hed_parse and hed_emit
// Bytes enter through a one-word input register; a single pass of logic then
// decodes the word against the entity state and the 49-name rom and loads the
// whole run of result bytes into the output register, which hands them out one
// word per cycle while rsp_stall is low. Plain text thus flows at one byte per
// clock when the output does not stall, passing through the input register and
// then the output register. A word that yields more than one byte (a two-byte
// replacement, or a raw flush of up to MAX_NAME_LEN + 2 bytes) holds the output
// register until its last byte is taken, since the result port carries one byte
// per cycle; the next word waits in the input register meanwhile. No reset sweep is needed.
module html_entity_decoder #(
   parameter int ENTRY_COUNT  = 49,
   parameter int MAX_NAME_LEN = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);
   import hed_pkg::*;

   localparam int OUT_CAP = MAX_NAME_LEN + 2;

   run_ctl_type run_ctl;
   logic [7:0]  run_bytes [OUT_CAP];
   logic        emit_free;

   hed_parse #(
      .ENTRY_COUNT  (ENTRY_COUNT),
      .MAX_NAME_LEN (MAX_NAME_LEN)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_end  (req_in_end),
      .emit_free   (emit_free),
      .run_ctl     (run_ctl),
      .run_bytes   (run_bytes)
   );

   hed_emit #(
      .OUT_CAP (OUT_CAP)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .run_ctl        (run_ctl),
      .run_bytes      (run_bytes),
      .emit_free      (emit_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

FILE: src/hed_match.sv
// exact parallel compare of the buffered entity name against the rom
// depends on hed_pkg
module hed_match #(
   parameter int ENTRY_COUNT  = 49,
   parameter int MAX_NAME_LEN = 6
) (
   input  logic [7:0]                         name [MAX_NAME_LEN],
   input  logic [$clog2(MAX_NAME_LEN+1)-1:0]  name_len,
   output hed_pkg::match_type                 result
);
   import hed_pkg::*;

   localparam int ENTRY_USED = (ENTRY_COUNT < ROM_SIZE) ? ENTRY_COUNT : ROM_SIZE;

   logic [7:0] pad [ROM_TEXT_LEN];

   for (genvar j = 0; j < ROM_TEXT_LEN; j++) begin : g_pad
      if (j < MAX_NAME_LEN) begin : g_used
         assign pad[j] = name[j];
      end else begin : g_zero
         assign pad[j] = '0;
      end
   end

   always_comb begin
      logic eq;
      result = '0;
      for (int i = 0; i < ENTRY_USED; i++) begin
         eq = (5'(ROM[i].len) == 5'(name_len));
         for (int j = 0; j < ROM_TEXT_LEN; j++) begin
            if (j < int'(ROM[i].len) && pad[j] != rom_char(i, j)) begin
               eq = 1'b0;
            end
         end
         // rom names are distinct, so at most one entry hits
         if (eq) begin
            result.hit = 1'b1;
            result.two = result.two | ROM[i].two;
            result.b0  = result.b0 | ROM[i].b0;
            result.b1  = result.b1 | ROM[i].b1;
         end
      end
   end

endmodule

FILE: src/hed_parse.sv
// input word register, entity state and construction of the output run per word
// depends on hed_pkg and hed_match
module hed_parse #(
   parameter int ENTRY_COUNT  = 49,
   parameter int MAX_NAME_LEN = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_in_end,
   input  logic                  emit_free,
   output hed_pkg::run_ctl_type  run_ctl,
   output logic [7:0]            run_bytes [MAX_NAME_LEN+2]
);
   import hed_pkg::*;

   localparam int OUT_CAP = MAX_NAME_LEN + 2;
   localparam int LEN_W   = $clog2(MAX_NAME_LEN + 1);
   localparam int IDX_W   = $clog2(MAX_NAME_LEN);

   logic             item_valid_ff;
   logic [7:0]       byte_ff;
   logic             end_ff;
   logic             in_entity_ff, in_entity_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       name_ff [MAX_NAME_LEN];
   logic [7:0]       name_in [MAX_NAME_LEN];

   logic                 advance;
   logic                 is_amp, is_semi;
   logic [7:0]           tail_byte;
   logic                 plain_emit, hit_emit;
   logic [RUN_CNT_W-1:0] count;
   match_type            match;

   hed_match #(
      .ENTRY_COUNT  (ENTRY_COUNT),
      .MAX_NAME_LEN (MAX_NAME_LEN)
   ) u_match (
      .name     (name_ff),
      .name_len (len_ff),
      .result   (match)
   );

   always_comb begin
      advance      = item_valid_ff && emit_free;
      req_stall    = item_valid_ff && !emit_free;
      is_amp       = (byte_ff == AMP_CHAR);
      is_semi      = (byte_ff == SEMI_CHAR);
      in_entity_in = in_entity_ff;
      len_in       = len_ff;
      name_in      = name_ff;
      tail_byte    = byte_ff;
      plain_emit   = 1'b0;
      hit_emit     = 1'b0;
      count        = '0;

      priority if (!in_entity_ff) begin
         if (is_amp) begin
            in_entity_in = 1'b1;
            len_in       = '0;
         end else begin
            plain_emit = 1'b1;
            count      = RUN_CNT_W'(1);
         end
      end else if (is_semi) begin
         if (match.hit) begin
            hit_emit = 1'b1;
            count    = match.two ? RUN_CNT_W'(2) : RUN_CNT_W'(1);
         end else begin
            count = RUN_CNT_W'(len_ff) + RUN_CNT_W'(2);
         end
         in_entity_in = 1'b0;
         len_in       = '0;
      end else if (is_amp) begin
         // second ampersand flushes the name raw and reopens
         count  = RUN_CNT_W'(len_ff) + RUN_CNT_W'(1);
         len_in = '0;
      end else if (len_ff < LEN_W'(MAX_NAME_LEN)) begin
         name_in[len_ff[IDX_W-1:0]] = byte_ff;
         len_in = len_ff + 1'b1;
      end else begin
         // overflow
         count        = RUN_CNT_W'(len_ff) + RUN_CNT_W'(2);
         in_entity_in = 1'b0;
         len_in       = '0;
      end

      // end of stream closes an open entity raw
      if (end_ff && in_entity_in) begin
         in_entity_in = 1'b0;
         len_in       = '0;
         if (!in_entity_ff) begin
            count = RUN_CNT_W'(1);
         end else begin
            count = RUN_CNT_W'(len_ff) + RUN_CNT_W'(2);
         end
      end

      run_ctl.load       = advance && (count != '0);
      run_ctl.count      = count;
      run_ctl.stream_end = end_ff;
   end

   // run layout: '&', name bytes, tail byte right after the name; plain and hit runs overwrite the head
   always_comb begin
      run_bytes[0] = AMP_CHAR;
      for (int k = 1; k < OUT_CAP; k++) begin
         if (k - 1 < MAX_NAME_LEN) begin
            run_bytes[k] = name_ff[k-1];
         end else begin
            run_bytes[k] = byte_ff;
         end
      end
      for (int k = 1; k < OUT_CAP; k++) begin
         if (RUN_CNT_W'(k) == RUN_CNT_W'(len_ff) + RUN_CNT_W'(1)) begin
            run_bytes[k] = tail_byte;
         end
      end
      if (is_amp && in_entity_ff) begin
         for (int k = 1; k < OUT_CAP; k++) begin
            if (RUN_CNT_W'(k) == RUN_CNT_W'(len_ff) + RUN_CNT_W'(1)) begin
               run_bytes[k] = AMP_CHAR;
            end
         end
      end
      if (is_semi && in_entity_ff && !hit_emit) begin
         for (int k = 1; k < OUT_CAP; k++) begin
            if (RUN_CNT_W'(k) == RUN_CNT_W'(len_ff) + RUN_CNT_W'(1)) begin
               run_bytes[k] = SEMI_CHAR;
            end
         end
      end
      if (plain_emit) begin
         run_bytes[0] = byte_ff;
      end
      if (hit_emit) begin
         run_bytes[0] = match.b0;
         run_bytes[1] = match.b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         in_entity_ff  <= 1'b0;
         len_ff        <= '0;
      end else begin
         if (!req_stall) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            in_entity_ff <= in_entity_in;
            len_ff       <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_in_byte;
         end_ff  <= req_in_end;
      end
      if (advance) begin
         name_ff <= name_in;
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_NAME_LEN))
      else $error("name length beyond buffer");

   a_len_idle: assert property (@(posedge clock) disable iff (reset)
      !in_entity_ff |-> len_ff == '0)
      else $error("name length held outside an entity");

endmodule

FILE: src/hed_emit.sv
// result register: holds one run of bytes and hands it out one word per cycle while rsp_stall is low
// depends on hed_pkg
module hed_emit #(
   parameter int OUT_CAP = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hed_pkg::run_ctl_type run_ctl,
   input  logic [7:0]           run_bytes [OUT_CAP],
   output logic                 emit_free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_stream_end
);
   import hed_pkg::*;

   localparam int IDX_W = $clog2(OUT_CAP);
   localparam int CNT_W = $clog2(OUT_CAP + 1);

   logic             valid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] count_ff;
   logic             end_ff;
   logic [7:0]       bytes_ff [OUT_CAP];
   logic             take, last;

   always_comb begin
      last           = (CNT_W'(idx_ff) + 1'b1 == count_ff);
      take           = valid_ff && !rsp_stall;
      emit_free      = !valid_ff || (take && last);
      rsp_valid      = valid_ff;
      rsp_out_byte   = bytes_ff[idx_ff];
      rsp_run_last   = last;
      rsp_stream_end = last && end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (emit_free) begin
            valid_ff <= run_ctl.load;
            idx_ff   <= '0;
         end else if (take) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_free && run_ctl.load) begin
         bytes_ff <= run_bytes;
         count_ff <= run_ctl.count[CNT_W-1:0];
         end_ff   <= run_ctl.stream_end;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (count_ff != '0) && (CNT_W'(idx_ff) < count_ff))
      else $error("run index outside run");

   a_step: assert property (@(posedge clock) disable iff (reset)
      take && !last |=> valid_ff && idx_ff == $past(idx_ff) + 1'b1)
      else $error("run index did not advance");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("stream end off the last word of a run");

endmodule
